// ===== design/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache table: entry layout,
// request and status codes, result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 8;
	localparam int LIFE_W      = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// request kinds carried on the input tuser
	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_ADD     = 2'd1,
		REQ_LOOKUP  = 2'd2,
		REQ_ABANDON = 2'd3
	} req_e;

	// result status codes carried on the output tuser
	typedef enum logic [2:0] {
		ST_HIT         = 3'd0,
		ST_INSERTED    = 3'd1,
		ST_PENDING_NEW = 3'd2,
		ST_PENDING_OLD = 3'd3,
		ST_FULL        = 3'd4,
		ST_NONE        = 3'd5
	} status_e;

	// one table entry as stored in the memory; life of zero means slot free
	typedef struct packed {
		logic [31:0]       ip;
		logic [47:0]       mac;
		logic              resolved;
		logic [LIFE_W-1:0] life;
	} entry_t;

	// result of one request, handed from the sequencer to the output stage
	typedef struct packed {
		status_e    status;
		logic [47:0] mac;
		logic [2:0]  index;
		logic        need;
		logic [3:0]  expired;
	} res_t;

endpackage

`default_nettype wire

// ===== design/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// arpc_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/arpc_seq.sv =====
// ----------------------------------------------------------------------------
// arpc_seq
// Request sequencer: scans the entry memory one slot a cycle, ages entries
// on a tick, then applies the add, lookup or abandon to the chosen slot.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_seq import arpc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request side
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire req_e              in_req,
	input  wire logic [31:0]       in_ip,
	input  wire logic [47:0]       in_mac,
	input  wire logic [LIFE_W-1:0] lifetime,
	// result side
	output logic                   res_valid,
	input  wire logic              res_take,
	output res_t                   res,
	// entry memory
	output logic                   mem_re,
	output logic [IDX_W-1:0]       mem_raddr,
	input  wire entry_t            mem_rdata,
	output logic                   mem_we,
	output logic [IDX_W-1:0]       mem_waddr,
	output entry_t                 mem_wdata
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_ACT  = 4'b0100,
		S_DONE = 4'b1000
	} state_e;

	state_e state_q;
	req_e   req_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [CNT_W-1:0] issue_q;
	logic [CNT_W-1:0] exp_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             wr_s1;
	logic             match_hit_q;
	logic [IDX_W-1:0] match_idx_q;
	logic             match_res_q;
	logic [47:0]      match_mac_q;
	logic             free_hit_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [TABLE_DEPTH-1:0] wr_bits_q;
	res_t             res_q;

	logic        accept;
	logic        scan_last;
	entry_t      ent;
	logic [LIFE_W-1:0] life_dec;
	logic        tick_we;
	logic        tick_expire;
	logic        act_we;
	logic        act_clear;
	logic [IDX_W-1:0] act_idx;
	entry_t      act_wdata;
	res_t        act_res;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// read issue: one slot a cycle during the scan
	assign mem_re    = (state_q == S_SCAN) && (issue_q < CNT_W'(TABLE_DEPTH));
	assign mem_raddr = issue_q[IDX_W-1:0];

	// returned entry; a slot never written reads as all zero
	assign ent       = wr_s1 ? mem_rdata : '0;
	assign scan_last = vld_s1 && (idx_s1 == IDX_W'(TABLE_DEPTH - 1));

	// aging on a tick
	assign life_dec    = ent.life - LIFE_W'(1);
	assign tick_we     = vld_s1 && (req_q == REQ_TICK) && (ent.life != '0);
	assign tick_expire = tick_we && (life_dec == '0);

	// apply the request to the chosen slot once the scan is over
	always_comb begin
		act_we    = 1'b0;
		act_clear = 1'b0;
		act_idx   = match_idx_q;
		act_wdata = '{ip: ip_q, mac: mac_q, resolved: 1'b1, life: lifetime};
		act_res   = '{status: ST_NONE, mac: '0, index: '0, need: 1'b0, expired: '0};
		case (req_q)
			REQ_TICK: begin
				act_res.expired = 4'(exp_q);
			end
			REQ_ADD: begin
				if (match_hit_q) begin
					act_we         = 1'b1;
					act_res.status = ST_HIT;
					act_res.index  = 3'(match_idx_q);
				end else if (free_hit_q) begin
					act_we         = 1'b1;
					act_idx        = free_idx_q;
					act_res.status = ST_INSERTED;
					act_res.index  = 3'(free_idx_q);
				end else begin
					act_res.status = ST_FULL;
				end
			end
			REQ_LOOKUP: begin
				if (match_hit_q) begin
					act_res.index = 3'(match_idx_q);
					if (match_res_q) begin
						act_res.status = ST_HIT;
						act_res.mac    = match_mac_q;
					end else begin
						act_res.status = ST_PENDING_OLD;
						act_res.need   = 1'b1;
					end
				end else if (free_hit_q) begin
					act_we             = 1'b1;
					act_idx            = free_idx_q;
					act_wdata.mac      = '0;
					act_wdata.resolved = 1'b0;
					act_res.status     = ST_PENDING_NEW;
					act_res.index      = 3'(free_idx_q);
					act_res.need       = 1'b1;
				end else begin
					act_res.status = ST_FULL;
				end
			end
			REQ_ABANDON: begin
				if (match_hit_q && !match_res_q) begin
					act_clear      = 1'b1;
					act_res.status = ST_HIT;
					act_res.index  = 3'(match_idx_q);
				end
			end
			default: begin
				act_res.status = ST_NONE;
			end
		endcase
	end

	// memory write port: tick write-back during the scan, update afterwards
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '{ip: ent.ip, mac: ent.mac, resolved: ent.resolved, life: life_dec};
		if ((state_q == S_SCAN) && tick_we && !tick_expire) begin
			mem_we = 1'b1;
		end else if ((state_q == S_ACT) && act_we) begin
			mem_we    = 1'b1;
			mem_waddr = act_idx;
			mem_wdata = act_wdata;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			issue_q   <= '0;
			vld_s1    <= 1'b0;
			wr_bits_q <= '0;
		end else begin
			vld_s1 <= mem_re;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						issue_q <= '0;
					end
				end
				S_SCAN: begin
					if (mem_re) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (tick_expire) begin
						wr_bits_q[idx_s1] <= 1'b0;
					end
					if (scan_last) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					if (act_we) begin
						wr_bits_q[act_idx] <= 1'b1;
					end
					if (act_clear) begin
						wr_bits_q[act_idx] <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, scan bookkeeping and result
	always_ff @(posedge clk) begin
		idx_s1 <= mem_raddr;
		wr_s1  <= wr_bits_q[mem_raddr];
		if (accept) begin
			req_q       <= in_req;
			ip_q        <= in_ip;
			mac_q       <= in_mac;
			exp_q       <= '0;
			match_hit_q <= 1'b0;
			free_hit_q  <= 1'b0;
		end else if ((state_q == S_SCAN) && vld_s1) begin
			// first occupied slot with this address
			if (!match_hit_q && (ent.life != '0) && (ent.ip == ip_q)) begin
				match_hit_q <= 1'b1;
				match_idx_q <= idx_s1;
				match_res_q <= ent.resolved;
				match_mac_q <= ent.mac;
			end
			// lowest free slot
			if (!free_hit_q && (ent.life == '0)) begin
				free_hit_q <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (tick_expire) begin
				exp_q <= exp_q + CNT_W'(1);
			end
		end
		if (state_q == S_ACT) begin
			res_q <= act_res;
		end
	end

	// checks
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN))
		else $error("accepted request did not start a scan");

	a_we_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == S_ACT) || ((state_q == S_SCAN) && (req_q == REQ_TICK))))
		else $error("entry write outside tick scan or update");

	a_exp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACT) |-> (exp_q <= CNT_W'(TABLE_DEPTH)))
		else $error("expired count beyond table depth");

	a_act_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACT) |=> (state_q == S_DONE))
		else $error("update step not followed by result");

endmodule

`default_nettype wire

// ===== design/arp_cache_table.sv =====
// ----------------------------------------------------------------------------
// arp_cache_table
// ARP cache of IPv4 to MAC entries with per-entry lifetime, stream interface.
// ----------------------------------------------------------------------------
// One request is handled at a time; the next is taken only once the result
// of the last has gone to the output register. The entry memory has a
// single read port with registered read data, so the sequencer reads one
// slot a cycle, then writes the chosen slot and hands the result to the
// output register. A finished result waits in that register while the next
// request is taken. A tick ages every slot during its scan and clears those
// that run out. There is no clearing pass after reset: a flop per slot marks
// it written, and an unwritten slot reads as free. default_lifetime may only
// be written while no request is in flight; a written value of zero is taken
// as one.
`default_nettype none

module arp_cache_table import arpc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: default_lifetime
	input  wire logic        cfg_wen,
	input  wire logic [15:0] cfg_wdata,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // ip_addr[31:0], mac_addr[79:32]
	input  wire logic [1:0]  s_tuser,   // req_type[1:0]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // mac_out[47:0], entry_index[50:48],
	                                    // request_needed[51], expired_count[55:52]
	output logic [2:0]       m_tuser    // status[2:0]
);

	localparam logic [LIFE_W-1:0] LIFE_RST = LIFE_W'(1000);

	logic [LIFE_W-1:0] life_q;
	logic [LIFE_W-1:0] cfg_life;
	logic              res_valid;
	logic              res_take;
	res_t              res;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	entry_t            mem_rdata;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;

	// lifetime register, zero stored as one
	assign cfg_life = LIFE_W'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= LIFE_RST;
		end else if (cfg_wen) begin
			life_q <= (cfg_life == '0) ? LIFE_W'(1) : cfg_life;
		end
	end

	arpc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (req_e'(s_tuser)),
		.in_ip     (s_tdata[31:0]),
		.in_mac    (s_tdata[79:32]),
		.lifetime  (life_q),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	arpc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: load when empty or being drained
	assign res_take = res_valid && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_take) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata <= {res.expired, res.need, res.index, res.mac};
			m_tuser <= res.status;
		end
	end

endmodule

`default_nettype wire

// ===== dv/arp_cache_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_cache_checker
// Watches the configuration port and both stream channels of the ARP cache.
// Keeps its own copy of the table, works out the reply to every request
// transfer, and compares each reply transfer field by field in order.
// ----------------------------------------------------------------------------

module arp_cache_checker import arpc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [79:0] s_tdata,   // ip_addr[31:0], mac_addr[79:32]
	input  wire logic [1:0]  s_tuser,   // req_type[1:0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [55:0] m_tdata,   // mac_out[47:0], entry_index[50:48],
	                                    // request_needed[51], expired_count[55:52]
	input  wire logic [2:0]  m_tuser,   // status[2:0]
	output int               pending_count,
	output int               mismatch_count
);

	// one reply as it should appear on the result channel
	typedef struct {
		status_e     status;
		logic [47:0] mac;
		logic [2:0]  slot;
		logic        need;
		logic [3:0]  expired;
	} reply_t;

	// shadow table; a zero lifetime marks a free slot
	logic [31:0]       slot_ip       [TABLE_DEPTH];
	logic [47:0]       slot_mac      [TABLE_DEPTH];
	logic              slot_resolved [TABLE_DEPTH];
	logic [LIFE_W-1:0] slot_life     [TABLE_DEPTH];
	logic [LIFE_W-1:0] life_setting;

	reply_t expected_replies[$];

	// first occupied slot holding this address
	function automatic int find_ip(logic [31:0] ip);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (slot_life[i] != '0 && slot_ip[i] == ip)
				return i;
		return -1;
	endfunction

	// lowest free slot
	function automatic int find_free();
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (slot_life[i] == '0)
				return i;
		return -1;
	endfunction

	function automatic void free_slot(int i);
		slot_ip[i]       = '0;
		slot_mac[i]      = '0;
		slot_resolved[i] = 1'b0;
		slot_life[i]     = '0;
	endfunction

	// apply one request to the shadow table and return its reply
	function automatic reply_t serve_request(req_e req, logic [31:0] ip, logic [47:0] mac);
		reply_t r;
		int     i;
		r.status  = ST_NONE;
		r.mac     = '0;
		r.slot    = '0;
		r.need    = 1'b0;
		r.expired = '0;
		case (req)
			REQ_TICK: begin
				// age every occupied slot, clear those that run out
				for (int k = 0; k < TABLE_DEPTH; k++) begin
					if (slot_life[k] != '0) begin
						slot_life[k] = slot_life[k] - 1'b1;
						if (slot_life[k] == '0) begin
							free_slot(k);
							r.expired = r.expired + 1'b1;
						end
					end
				end
			end
			REQ_ADD: begin
				// refresh a match, else take the lowest free slot
				i = find_ip(ip);
				if (i >= 0) begin
					r.status = ST_HIT;
				end else begin
					i = find_free();
					r.status = (i >= 0) ? ST_INSERTED : ST_FULL;
				end
				if (i >= 0) begin
					slot_ip[i]       = ip;
					slot_mac[i]      = mac;
					slot_resolved[i] = 1'b1;
					slot_life[i]     = life_setting;
					r.slot           = 3'(i);
				end
			end
			REQ_LOOKUP: begin
				i = find_ip(ip);
				if (i >= 0) begin
					r.slot = 3'(i);
					if (slot_resolved[i]) begin
						r.status = ST_HIT;
						r.mac    = slot_mac[i];
					end else begin
						r.status = ST_PENDING_OLD;
						r.need   = 1'b1;
					end
				end else begin
					// miss: open a pending entry if there is room
					i = find_free();
					if (i >= 0) begin
						slot_ip[i]       = ip;
						slot_mac[i]      = '0;
						slot_resolved[i] = 1'b0;
						slot_life[i]     = life_setting;
						r.slot           = 3'(i);
						r.status         = ST_PENDING_NEW;
						r.need           = 1'b1;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			REQ_ABANDON: begin
				// only a pending entry can be dropped
				i = find_ip(ip);
				if (i >= 0 && !slot_resolved[i]) begin
					free_slot(i);
					r.slot   = 3'(i);
					r.status = ST_HIT;
				end
			end
			default: begin
				r.status = ST_NONE;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// track config writes, predict on request transfers, check reply transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				free_slot(i);
			life_setting = 16'd1000;
			expected_replies.delete();
			pending_count <= 0;
		end else begin
			reply_t want;
			if (cfg_wen)
				life_setting = (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
				end else begin
					want = expected_replies.pop_front();
					if (m_tuser !== want.status)
						report_mismatch("status", 64'(m_tuser), 64'(want.status));
					if (m_tdata[47:0] !== want.mac)
						report_mismatch("mac_out", 64'(m_tdata[47:0]), 64'(want.mac));
					if (m_tdata[50:48] !== want.slot)
						report_mismatch("entry_index", 64'(m_tdata[50:48]), 64'(want.slot));
					if (m_tdata[51] !== want.need)
						report_mismatch("request_needed", 64'(m_tdata[51]), 64'(want.need));
					if (m_tdata[55:52] !== want.expired)
						report_mismatch("expired_count", 64'(m_tdata[55:52]),
							64'(want.expired));
				end
			end
			if (s_tvalid && s_tready)
				expected_replies.push_back(serve_request(req_e'(s_tuser), s_tdata[31:0],
					s_tdata[79:32]));
			pending_count <= expected_replies.size();
		end
	end

endmodule

// ===== dv/arp_cache_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_cache_table_test
// Drives the ARP cache with a directed sequence covering pending entries,
// refresh, abandon, a full table and mass expiry, then random requests over
// a small address pool across several lifetime settings, with random idle
// and stall bursts. Checking is done by arp_cache_checker.
// ----------------------------------------------------------------------------

module arp_cache_table_test;
	import arpc_pkg::*;

	localparam int PHASE_ITEMS = 200;
	localparam int NUM_PHASES  = 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = REQ_TICK;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;
	logic [2:0]  m_tuser;

	int          pending_count;
	int          mismatch_count;
	bit          idling     = 1'b0;
	int          stall_left = 0;
	logic [31:0] ip_pool[16];
	logic [15:0] phase_life[NUM_PHASES];

	arp_cache_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	arp_cache_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.pending_count  (pending_count),
		.mismatch_count (mismatch_count)
	);

	always #5 clk = ~clk;

	// hard stop well past the slowest correct run
	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	// random result side back-pressure bursts while idling is set
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 14);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one request transfer, with an optional idle burst ahead of it
	task automatic send_request(req_e req, logic [31:0] ip, logic [47:0] mac);
		if (idling && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {mac, ip};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every reply come back
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_lifetime(logic [15:0] ticks);
		wait_quiet();
		cfg_wen   <= 1'b1;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	function automatic logic [31:0] pick_ip();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return ip_pool[$urandom_range(0, 15)];
	endfunction

	function automatic logic [47:0] pick_mac();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return {16'($urandom), 32'($urandom)};
		endcase
	endfunction

	// ticks 20, adds 30, lookups 35, abandons 15 percent
	function automatic req_e pick_req();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return REQ_TICK;
		if (r < 50)
			return REQ_ADD;
		if (r < 85)
			return REQ_LOOKUP;
		return REQ_ABANDON;
	endfunction

	initial begin
		// small address pool so entries get hit, refreshed and abandoned
		ip_pool[0] = '0;
		ip_pool[1] = '1;
		for (int i = 2; i < 16; i++)
			ip_pool[i] = $urandom;
		phase_life = '{16'd1, 16'd2, 16'd4, 16'd7, 16'd16,
			16'($urandom_range(1, 30)), 16'd0, 16'hFFFF};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pending life cycle at the reset lifetime
		send_request(REQ_LOOKUP, '0, '0);
		send_request(REQ_LOOKUP, '0, '1);
		send_request(REQ_ABANDON, '0, '0);
		send_request(REQ_ABANDON, '0, '0);
		send_request(REQ_TICK, '1, '1);

		// directed: zero lifetime taken as one, fill the table, expire it all
		set_lifetime(16'd0);
		send_request(REQ_LOOKUP, '0, '0);
		send_request(REQ_ADD, '0, '1);
		send_request(REQ_LOOKUP, '0, '0);
		send_request(REQ_ABANDON, '0, '0);
		send_request(REQ_ADD, '1, '0);
		for (int i = 2; i < 8; i++)
			send_request(REQ_ADD, ip_pool[i], pick_mac());
		send_request(REQ_ADD, ip_pool[8], '1);
		send_request(REQ_LOOKUP, ip_pool[9], '0);
		send_request(REQ_TICK, '0, '0);

		// random phases, one lifetime setting each, quiet in the last one
		idling = 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_lifetime(phase_life[p]);
			idling = (p != NUM_PHASES - 1);
			repeat (PHASE_ITEMS)
				send_request(pick_req(), pick_ip(), pick_mac());
		end

		wait_quiet();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
